// ===== rtl/string_hash_bucket_assert.svh =====
// Assertion macros for the string hash bucket RTL.
`ifndef STRING_HASH_BUCKET_ASSERT_SVH
`define STRING_HASH_BUCKET_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shb_pkg.sv =====
package shb_pkg;

    // Field and datapath widths
    localparam int CHAR_W = 8;
    localparam int HASH_W = 32;
    localparam int CNT_W  = $clog2(HASH_W);

    // 33 = (1 << MULT_SHIFT) + 1
    localparam int MULT_SHIFT = 5;
    localparam int FOLD_SHIFT = 5;

    localparam logic [HASH_W-1:0] BUCKETS_AT_RESET = HASH_W'(1024);

    // Remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/shb_divider.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
// A zero divisor leaves the dividend itself as the remainder.
module shb_divider import shb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [HASH_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [HASH_W-1:0] remainder
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [HASH_W-1:0] dvd_reg;
    logic [HASH_W-1:0] dsr_reg;
    logic [HASH_W-1:0] rem_reg;

    logic [HASH_W:0]   rem_shift;
    logic [HASH_W:0]   rem_sub;
    logic [HASH_W-1:0] rem_next;

    // Shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[HASH_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        if (rem_shift >= {1'b0, dsr_reg}) begin
            rem_next = rem_sub[HASH_W-1:0];
        end else begin
            rem_next = rem_shift[HASH_W-1:0];
        end
    end

    // Control: busy until every dividend bit is processed, then a one-cycle done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/string_hash_bucket.sv =====
// String hash to bucket index.
// Input channel s_*: one string byte per transaction in s_tdata. A non-zero
// byte (taken as a signed char) updates the running hash acc = acc*33 + byte
// and bytes stream at one per cycle while s_tready is high. A zero byte ends
// the string. On the terminator the hash is folded (acc + (acc >> 5)) and
// reduced modulo bucket_count by a bit-serial remainder unit, one bit per
// cycle; s_tready is low from the terminator until the result is loaded.
// The result is registered onto m_tdata, and the next byte can be taken in
// the same cycle as it appears there.
// Output channel m_*: one transaction per string. A result held in the output
// register does not block bytes of the next string; a following terminator is
// still accepted, but its result waits for the receiver to free the register.
// cfg_wr_en/cfg_wr_data write bucket_count; write only while idle. A count of
// zero gives the folded hash itself.
// Reset (aresetn low, synchronous) clears the hash, drops m_tvalid and sets
// bucket_count to 1024.
`include "string_hash_bucket_assert.svh"

module string_hash_bucket import shb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration
    input  logic              cfg_wr_en,
    input  logic [HASH_W-1:0] cfg_wr_data,     // bucket_count
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,         // [7:0] char_byte
    // Result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [HASH_W-1:0] m_tdata          // [31:0] bucket_index
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [HASH_W-1:0] bucket_count_reg;
    logic              m_valid_reg, m_valid_next;
    logic [HASH_W-1:0] m_data_reg;

    logic              s_xfer;
    logic              term;
    logic              out_free;
    logic              load_out;
    logic [HASH_W-1:0] char_sext;
    logic [HASH_W-1:0] acc_upd;
    logic [HASH_W-1:0] fold;
    div_stat_t         div_stat;
    logic [HASH_W-1:0] div_rem;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign term     = s_xfer && (s_tdata == '0);
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    // Hash update and fold
    assign char_sext = {{(HASH_W-CHAR_W){s_tdata[CHAR_W-1]}}, s_tdata};
    assign acc_upd   = (acc_reg << MULT_SHIFT) + acc_reg + char_sext;
    assign fold      = acc_reg + (acc_reg >> FOLD_SHIFT);

    shb_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (term),
        .dividend  (fold),
        .divisor   (bucket_count_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // Sequencer and accumulator
    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (term) begin
                    acc_next   = '0;
                    state_next = ST_DIV;
                end else if (s_xfer) begin
                    acc_next = acc_upd;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            acc_reg          <= '0;
            bucket_count_reg <= BUCKETS_AT_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                bucket_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= div_rem;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `SHB_ASSERT_NOW(a_no_accept_busy, aclk, aresetn, div_stat.busy, !s_tready,
        "byte accepted while remainder unit busy")
    `SHB_ASSERT_NOW(a_done_in_div, aclk, aresetn, div_stat.done, state_reg == ST_DIV,
        "remainder done outside divide phase")
    `SHB_ASSERT_NEXT(a_term_starts, aclk, aresetn, term, div_stat.busy && acc_reg == '0,
        "terminator did not start remainder unit or clear hash")
    `SHB_ASSERT_NEXT(a_load_valid, aclk, aresetn, load_out, m_tvalid,
        "result load did not raise m_tvalid")

endmodule
